// ===== hdl/bmss_pkg.sv =====
// Package for the bad-character substring search block.
// Holds shared constants, register codes and the cell control struct; no dependencies.
package bmss_pkg;

   localparam int TEXT_DEPTH_DEF  = 1024;
   localparam int PATTERN_MAX_DEF = 16;

   localparam int LEN_W      = 5;
   localparam int OFFSET_W   = 10;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [1:0] {
      REG_PATTERN_LOW    = 2'd0,
      REG_PATTERN_HIGH   = 2'd1,
      REG_PATTERN_LENGTH = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

// ===== hdl/bmss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bmss_cell.sv =====
// One compare cell of the match row: holds the partial-match flag for one pattern position.
// Depends on bmss_pkg.
module bmss_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  bmss_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]             text_byte,
   input  logic [7:0]             pattern_byte,
   input  logic                   flag_prev,
   output logic                   flag
);

   logic flag_ff;
   logic flag_in;

   always_comb begin
      flag_in = flag_ff;
      if (ctrl.clear) begin
         flag_in = 1'b0;
      end else if (ctrl.shift) begin
         flag_in = flag_prev & (text_byte == pattern_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   assign flag = flag_ff;

endmodule

// ===== hdl/boyer_moore_substring_search.sv =====
// Top level of the substring search block: text buffer, cell row, sequencer, register port.
// Depends on bmss_pkg, bmss_ram and bmss_cell.
//
//   channel  | ports         | transaction
//   ---------+---------------+------------------------------------------------
//   input    | req_t*        | one text byte, tlast marks the final byte
//   result   | rsp_t*        | found, match offset, overflow; one per text
//   config   | csr_p*        | pattern bytes 0-7, 8-15, length at 0x0/0x8/0x10
//
// Loading takes one byte per cycle. After the final byte the stored n bytes are
// streamed from the single RAM read port through the cell row, one per cycle; the
// row then drains and the result is registered. req_tready stays low during the search
// and while a finished result waits behind an earlier one. Synchronous active-high reset.
module boyer_moore_substring_search #(
   parameter int TEXT_DEPTH  = bmss_pkg::TEXT_DEPTH_DEF,
   parameter int PATTERN_MAX = bmss_pkg::PATTERN_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bmss_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] text_byte
   input  logic                            req_tlast,  // last_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bmss_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [0] found, [10:1] match_offset,
                                                       // [11] text_overflow, [15:12] zero
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bmss_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bmss_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bmss_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int AW = $clog2(TEXT_DEPTH);
   localparam int CW = $clog2(TEXT_DEPTH + 1);
   localparam int PW = $clog2(PATTERN_MAX);
   localparam int LW = bmss_pkg::LEN_W;
   localparam int OW = bmss_pkg::OFFSET_W;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              feed_vld_ff, feed_vld_in;
   logic [AW-1:0]     feed_idx_ff, feed_idx_in;
   logic              hit_vld_ff, hit_vld_in;
   logic [AW-1:0]     hit_idx_ff, hit_idx_in;
   logic              found_ff, found_in;
   logic [AW-1:0]     offset_ff, offset_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [OW-1:0]     rsp_off_ff, rsp_off_in;
   logic              rsp_ovf_ff, rsp_ovf_in;
   logic [63:0]       pat_lo_ff, pat_lo_in;
   logic [63:0]       pat_hi_ff, pat_hi_in;
   logic [LW-1:0]     len_ff, len_in;

   logic              in_fire;
   logic              has_room;
   logic              rd_en;
   logic [7:0]        rd_data;
   logic [127:0]      pat_vec;
   logic [LW-1:0]     m_eff;
   logic [LW-1:0]     m_minus1;
   logic [PATTERN_MAX-1:0] flags;
   logic              match_now;
   logic [OW+AW-1:0]  offset_wide;
   logic              csr_wr;
   bmss_pkg::csr_reg_type   csr_reg;
   bmss_pkg::cell_ctrl_type cell_ctrl;

   assign req_tready = (state_ff == ST_LOAD);
   assign in_fire    = req_tvalid & req_tready;
   assign has_room   = (count_ff < CW'(TEXT_DEPTH));
   assign rd_en      = (state_ff == ST_SCAN) && (scan_ff < count_ff);

   assign pat_vec  = {pat_hi_ff, pat_lo_ff};
   assign m_eff    = (len_ff > LW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : len_ff;
   assign m_minus1 = m_eff - LW'(1);
   assign match_now = hit_vld_ff && (m_eff != '0) && flags[m_minus1[PW-1:0]];

   assign cell_ctrl.shift = feed_vld_ff;
   assign cell_ctrl.clear = in_fire & req_tlast;

   assign csr_wr  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_reg = bmss_pkg::csr_reg_type'(csr_paddr[4:3]);
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_reg)
         bmss_pkg::REG_PATTERN_LOW:    csr_prdata = pat_lo_ff;
         bmss_pkg::REG_PATTERN_HIGH:   csr_prdata = pat_hi_ff;
         bmss_pkg::REG_PATTERN_LENGTH: csr_prdata = 64'(len_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   bmss_ram #(
      .WIDTH(8),
      .DEPTH(TEXT_DEPTH)
   ) u_text_ram (
      .clock  (clock),
      .wr_en  (in_fire & has_room),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(req_tdata[7:0]),
      .rd_en  (rd_en),
      .rd_addr(scan_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic flag_prev;
      if (k == 0) begin : g_first
         assign flag_prev = 1'b1;
      end else begin : g_rest
         assign flag_prev = flags[k-1];
      end
      bmss_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .text_byte   (rd_data),
         .pattern_byte(pat_vec[8*k +: 8]),
         .flag_prev   (flag_prev),
         .flag        (flags[k])
      );
   end

   assign offset_wide = (OW+AW)'(offset_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      scan_in      = scan_ff;
      feed_vld_in  = 1'b0;
      feed_idx_in  = feed_idx_ff;
      hit_vld_in   = feed_vld_ff;
      hit_idx_in   = feed_idx_ff;
      found_in     = found_ff;
      offset_in    = offset_ff;
      rsp_vld_in   = rsp_vld_ff & ~rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      pat_lo_in    = pat_lo_ff;
      pat_hi_in    = pat_hi_ff;
      len_in       = len_ff;

      if (csr_wr) begin
         unique case (csr_reg)
            bmss_pkg::REG_PATTERN_LOW:    pat_lo_in = csr_pwdata;
            bmss_pkg::REG_PATTERN_HIGH:   pat_hi_in = csr_pwdata;
            bmss_pkg::REG_PATTERN_LENGTH: len_in    = csr_pwdata[LW-1:0];
            default: ;
         endcase
      end

      if (match_now && !found_ff) begin
         found_in  = 1'b1;
         offset_in = hit_idx_ff - AW'(m_minus1);
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (in_fire) begin
               if (has_room) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_SCAN;
                  scan_in  = '0;
                  found_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               feed_vld_in = 1'b1;
               feed_idx_in = scan_ff[AW-1:0];
               scan_in     = scan_ff + CW'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!feed_vld_ff && !hit_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in   = 1'b1;
               rsp_found_in = found_ff;
               rsp_off_in   = found_ff ? offset_wide[OW-1:0] : '0;
               rsp_ovf_in   = ovf_ff;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         scan_ff     <= '0;
         feed_vld_ff <= 1'b0;
         hit_vld_ff  <= 1'b0;
         found_ff    <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         pat_lo_ff   <= '0;
         pat_hi_ff   <= '0;
         len_ff      <= LW'(1);
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         scan_ff     <= scan_in;
         feed_vld_ff <= feed_vld_in;
         hit_vld_ff  <= hit_vld_in;
         found_ff    <= found_in;
         rsp_vld_ff  <= rsp_vld_in;
         pat_lo_ff   <= pat_lo_in;
         pat_hi_ff   <= pat_hi_in;
         len_ff      <= len_in;
      end
      feed_idx_ff  <= feed_idx_in;
      hit_idx_ff   <= hit_idx_in;
      offset_ff    <= offset_in;
      rsp_found_ff <= rsp_found_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0000, rsp_ovf_ff, rsp_off_ff, rsp_found_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TEXT_DEPTH))
      else $error("text count beyond buffer depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (scan_ff <= count_ff))
      else $error("scan address passed the stored text");

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input accepted during search");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[10:1] == '0))
      else $error("nonzero offset without a match");

endmodule
